/* hw/rtl/nbm_pkg.sv */
package nbm_pkg;

   // Default node count of the matcher
   localparam int NODES_DEFAULT = 64;

   // Stream and register port widths
   localparam int REQ_DATA_W = 96;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 8;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W = 7;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_START_NODE   = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACTIVE_NODES = 1'b1;

   // Edge codes
   localparam logic signed [6:0] EDGE_NONE   = -7'sd1;
   localparam logic signed [6:0] EDGE_ACCEPT = -7'sd2;

   typedef enum logic [1:0] {
      REQ_LOAD_DESC = 2'd0,
      REQ_LOAD_SET  = 2'd1,
      REQ_FEED      = 2'd2,
      REQ_RESTART   = 2'd3
   } req_kind_type;

   // Payload fields of one request beat
   typedef struct packed {
      logic [5:0]        node_index;
      logic              node_is_epsilon;
      logic signed [6:0] edge_first;
      logic signed [6:0] edge_second;
      logic [1:0]        word_select;
      logic [63:0]       set_word;
      logic [7:0]        byte_in;
   } item_type;

   // Node descriptor circulating around the ring of cells
   typedef struct packed {
      logic              fire;
      logic signed [6:0] edge_first;
      logic signed [6:0] edge_second;
   } desc_type;

   // Flags collected along the chain during one lap
   typedef struct packed {
      logic rise;
      logic acc;
      logic live;
   } sweep_type;

   // Controls broadcast from the sequencer to every cell
   typedef struct packed {
      item_type    item;
      logic        wr_desc;
      logic        wr_set;
      logic        start;
      logic        refresh;
      logic        run;
      logic        commit;
      logic        feed;
      logic        restart;
      logic [5:0]  start_node;
      logic [6:0]  active_nodes;
   } ctl_type;

endpackage

/* hw/rtl/nbm_cell.sv */
module nbm_cell #(
   parameter int NODES = nbm_pkg::NODES_DEFAULT,
   parameter int Index = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  nbm_pkg::ctl_type    ctl,
   input  nbm_pkg::desc_type   desc_prev,
   input  nbm_pkg::sweep_type  sweep_prev,
   output nbm_pkg::desc_type   desc_out,
   output nbm_pkg::sweep_type  sweep_out
);
   import nbm_pkg::*;

   logic              active_ff, active_in;
   logic              eps_ff, eps_in;
   logic signed [6:0] e_first_ff, e_first_in;
   logic signed [6:0] e_second_ff, e_second_in;
   logic [63:0]       cset_ff [4];
   logic              reached_ff, reached_in;
   logic              fire_ff, fire_in;
   logic              rise_ff, rise_in;
   logic              acc_ff, acc_in;
   desc_type          desc_ff, desc_in;
   sweep_type         sweep_ff, sweep_in;

   logic        in_range;
   logic        sel_node;
   logic        hit_first;
   logic        hit_second;
   logic        hit;
   logic        has_acc;
   logic [63:0] cs_word;
   logic        cs_bit;
   logic        source;
   logic        start_hit;
   logic        live_loc;
   desc_type    own_desc;

   // Decode node position against the registers
   assign in_range  = 32'(ctl.active_nodes) > Index;
   assign sel_node  = 32'(ctl.item.node_index) == Index;
   assign start_hit = ctl.restart & in_range & (32'(ctl.start_node) == Index);

   // Match the passing descriptor's edges to this node
   assign hit_first  = !desc_ff.edge_first[6] && (32'(desc_ff.edge_first[5:0]) == Index);
   assign hit_second = !desc_ff.edge_second[6] && (32'(desc_ff.edge_second[5:0]) == Index);
   assign hit        = ctl.run & desc_ff.fire & in_range & (hit_first | hit_second);
   assign has_acc    = (e_first_ff == EDGE_ACCEPT) || (e_second_ff == EDGE_ACCEPT);

   // Look up the fed byte in this node's set
   assign cs_word = cset_ff[ctl.item.byte_in[7:6]];
   assign cs_bit  = cs_word[ctl.item.byte_in[5:0]];
   assign source  = ctl.feed & active_ff & ~eps_ff & in_range & cs_bit;

   assign live_loc = (ctl.feed | ctl.restart) ? (reached_ff & ~eps_ff & in_range)
                                              : (active_ff & in_range);

   always_comb begin
      own_desc.fire        = fire_in;
      own_desc.edge_first  = e_first_ff;
      own_desc.edge_second = e_second_ff;
   end

   // Node descriptor writes and the active bit
   always_comb begin
      eps_in      = eps_ff;
      e_first_in  = e_first_ff;
      e_second_in = e_second_ff;
      active_in   = active_ff;
      if (ctl.wr_desc && sel_node) begin
         eps_in      = ctl.item.node_is_epsilon;
         e_first_in  = ctl.item.edge_first;
         e_second_in = ctl.item.edge_second;
      end
      if (ctl.commit) begin
         active_in = reached_ff & ~eps_ff;
      end
   end

   // Closure walk: seed, refresh at lap ends, pass descriptors along the ring
   always_comb begin
      reached_in = reached_ff;
      fire_in    = fire_ff;
      rise_in    = rise_ff;
      acc_in     = acc_ff;
      desc_in    = desc_ff;
      if (ctl.start) begin
         reached_in = start_hit;
         fire_in    = source | (start_hit & eps_ff);
         rise_in    = fire_in;
         acc_in     = fire_in & has_acc;
         desc_in    = own_desc;
      end else if (ctl.refresh) begin
         reached_in = reached_ff | hit;
         fire_in    = fire_ff | (reached_in & eps_ff);
         rise_in    = fire_in & ~fire_ff;
         acc_in     = acc_ff | (fire_in & has_acc);
         desc_in    = own_desc;
      end else if (ctl.run) begin
         reached_in = reached_ff | hit;
         desc_in    = desc_prev;
      end
   end

   // Accumulate lap flags toward the chain end
   always_comb begin
      sweep_in = sweep_ff;
      if (ctl.run) begin
         sweep_in.rise = sweep_prev.rise | rise_ff;
         sweep_in.acc  = sweep_prev.acc | acc_ff;
         sweep_in.live = sweep_prev.live | live_loc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= (Index == 0);
         eps_ff      <= 1'b0;
         e_first_ff  <= EDGE_NONE;
         e_second_ff <= EDGE_NONE;
         reached_ff  <= 1'b0;
         fire_ff     <= 1'b0;
         rise_ff     <= 1'b0;
         acc_ff      <= 1'b0;
         desc_ff     <= '0;
         sweep_ff    <= '0;
      end else begin
         active_ff   <= active_in;
         eps_ff      <= eps_in;
         e_first_ff  <= e_first_in;
         e_second_ff <= e_second_in;
         reached_ff  <= reached_in;
         fire_ff     <= fire_in;
         rise_ff     <= rise_in;
         acc_ff      <= acc_in;
         desc_ff     <= desc_in;
         sweep_ff    <= sweep_in;
      end
   end

   // Hold set words until written
   always_ff @(posedge clock) begin
      if (ctl.wr_set && sel_node) begin
         cset_ff[ctl.item.word_select] <= ctl.item.set_word;
      end
   end

   assign desc_out  = desc_ff;
   assign sweep_out = sweep_ff;

endmodule

/* hw/rtl/nbm_ctrl.sv */
module nbm_ctrl #(
   parameter int NODES = nbm_pkg::NODES_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  nbm_pkg::req_kind_type                req_kind,
   input  nbm_pkg::item_type                    req_item,
   input  logic                                 csr_we,
   input  logic [nbm_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [nbm_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  nbm_pkg::sweep_type                   sweep_last,
   output nbm_pkg::ctl_type                     ctl,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic                                 rsp_matched,
   output logic                                 rsp_any_active
);
   import nbm_pkg::*;

   localparam int PhW = (NODES > 1) ? $clog2(NODES) : 1;
   localparam logic [PhW-1:0] PH_LAST = PhW'(NODES - 1);

   typedef enum logic [1:0] {
      IDLE,
      LAP,
      HOLD
   } state_type;

   state_type     state_ff, state_in;
   logic [PhW-1:0] ph_ff, ph_in;
   logic          lap_seen_ff, lap_seen_in;
   req_kind_type  kind_ff, kind_in;
   logic [5:0]    start_node_ff, start_node_in;
   logic [6:0]    active_nodes_ff, active_nodes_in;
   logic          live_ff, live_in;
   logic          live_ok_ff, live_ok_in;
   logic          res_matched_ff, res_matched_in;
   logic          res_live_ff, res_live_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_matched_ff, rsp_matched_in;
   logic          rsp_live_ff, rsp_live_in;

   logic         accept;
   logic         is_load;
   logic         sweep_start;
   logic         boundary;
   logic         done;
   logic         slot_free;
   logic         push;
   req_kind_type cur_kind;

   assign req_tready  = (state_ff == IDLE);
   assign accept      = req_tvalid & req_tready;
   assign is_load     = (req_kind == REQ_LOAD_DESC) || (req_kind == REQ_LOAD_SET);
   assign sweep_start = accept & (!is_load | !live_ok_ff);
   assign boundary    = (state_ff == LAP) && (ph_ff == PH_LAST);
   assign done        = (state_ff == LAP) && lap_seen_ff && (ph_ff == '0) && !sweep_last.rise;
   assign slot_free   = !rsp_valid_ff | rsp_tready;
   assign push        = (state_ff == HOLD) && slot_free;
   assign cur_kind    = sweep_start ? req_kind : kind_ff;

   // Broadcast controls to the cells
   always_comb begin
      ctl.item         = req_item;
      ctl.wr_desc      = accept && (req_kind == REQ_LOAD_DESC);
      ctl.wr_set       = accept && (req_kind == REQ_LOAD_SET);
      ctl.start        = sweep_start;
      ctl.refresh      = boundary;
      ctl.run          = (state_ff == LAP);
      ctl.commit       = done && ((kind_ff == REQ_FEED) || (kind_ff == REQ_RESTART));
      ctl.feed         = (cur_kind == REQ_FEED);
      ctl.restart      = (cur_kind == REQ_RESTART);
      ctl.start_node   = start_node_ff;
      ctl.active_nodes = active_nodes_ff;
   end

   // Sequence items, laps and the output register
   always_comb begin
      state_in        = state_ff;
      ph_in           = ph_ff;
      lap_seen_in     = lap_seen_ff;
      kind_in         = kind_ff;
      start_node_in   = start_node_ff;
      active_nodes_in = active_nodes_ff;
      live_in         = live_ff;
      live_ok_in      = live_ok_ff;
      res_matched_in  = res_matched_ff;
      res_live_in     = res_live_ff;
      rsp_valid_in    = rsp_valid_ff & ~rsp_tready;
      rsp_matched_in  = rsp_matched_ff;
      rsp_live_in     = rsp_live_ff;

      unique case (state_ff)
         IDLE: begin
            if (sweep_start) begin
               state_in    = LAP;
               ph_in       = '0;
               lap_seen_in = 1'b0;
               kind_in     = req_kind;
            end else if (accept) begin
               state_in       = HOLD;
               res_matched_in = 1'b0;
               res_live_in    = live_ff;
            end
         end
         LAP: begin
            if (boundary) begin
               ph_in       = '0;
               lap_seen_in = 1'b1;
            end else begin
               ph_in = PhW'(ph_ff + 1'b1);
            end
            if (done) begin
               state_in       = HOLD;
               res_matched_in = sweep_last.acc && (kind_ff == REQ_FEED);
               res_live_in    = sweep_last.live;
               live_in        = sweep_last.live;
               live_ok_in     = 1'b1;
            end
         end
         HOLD: begin
            if (slot_free) begin
               state_in       = IDLE;
               rsp_valid_in   = 1'b1;
               rsp_matched_in = res_matched_ff;
               rsp_live_in    = res_live_ff;
            end
         end
         default: state_in = IDLE;
      endcase

      // Register writes; a new node count drops the cached live flag
      if (csr_we) begin
         unique case (csr_index)
            CSR_START_NODE:   start_node_in = csr_wdata[5:0];
            CSR_ACTIVE_NODES: begin
               active_nodes_in = csr_wdata;
               live_ok_in      = 1'b0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= IDLE;
         ph_ff           <= '0;
         lap_seen_ff     <= 1'b0;
         kind_ff         <= REQ_LOAD_DESC;
         start_node_ff   <= 6'd0;
         active_nodes_ff <= 7'd64;
         live_ff         <= 1'b0;
         live_ok_ff      <= 1'b0;
         res_matched_ff  <= 1'b0;
         res_live_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         rsp_matched_ff  <= 1'b0;
         rsp_live_ff     <= 1'b0;
      end else begin
         state_ff        <= state_in;
         ph_ff           <= ph_in;
         lap_seen_ff     <= lap_seen_in;
         kind_ff         <= kind_in;
         start_node_ff   <= start_node_in;
         active_nodes_ff <= active_nodes_in;
         live_ff         <= live_in;
         live_ok_ff      <= live_ok_in;
         res_matched_ff  <= res_matched_in;
         res_live_ff     <= res_live_in;
         rsp_valid_ff    <= rsp_valid_in;
         rsp_matched_ff  <= rsp_matched_in;
         rsp_live_ff     <= rsp_live_in;
      end
   end

   assign rsp_tvalid     = rsp_valid_ff;
   assign rsp_matched    = rsp_matched_ff;
   assign rsp_any_active = rsp_live_ff;

   // A walk item always enters a fresh lap
   a_walk_starts_lap: assert property (@(posedge clock) disable iff (reset)
      (accept && ((req_kind == REQ_FEED) || (req_kind == REQ_RESTART)))
      |=> (state_ff == LAP && ph_ff == '0 && !lap_seen_ff))
      else $error("walk item did not start a lap");

   // A finished result lands in the output register
   a_push_fills_slot: assert property (@(posedge clock) disable iff (reset)
      push |=> (rsp_valid_ff && state_ff == IDLE))
      else $error("finished result not placed in output register");

   // Node count write invalidates the cached live flag
   a_count_drops_cache: assert property (@(posedge clock) disable iff (reset)
      (csr_we && csr_index == CSR_ACTIVE_NODES) |=> !live_ok_ff)
      else $error("live flag still cached after node count write");

   // Only a feed can report a match
   a_match_only_feed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == HOLD && res_matched_ff) |-> (kind_ff == REQ_FEED))
      else $error("match reported for a non-feed item");

endmodule

/* hw/rtl/nfa_byte_matcher.sv */
// Sequence: a load beat goes straight to the result while the live flag is cached, else it
//   runs a lap of the ring to collect the live flag; a restart or a feed runs laps of the
//   ring until a lap in which no new node fires.
// Throughput: one item at a time; one lap of the descriptor ring over the NODES cells sets
//   the step of the closure walk. The next beat is taken once the result is registered.
// Reset (synchronous): node 0 active, all edges none, epsilon flags clear, char sets undefined.
module nfa_byte_matcher #(
   parameter int NODES = nbm_pkg::NODES_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // node_index[5:0], node_is_epsilon[6], edge_first[13:7], edge_second[20:14],
   // word_select[22:21], set_word[86:23], byte_in[94:87], zero fill [95]
   input  logic [nbm_pkg::REQ_DATA_W-1:0]      req_tdata,
   // req_type[1:0]
   input  logic [nbm_pkg::REQ_USER_W-1:0]      req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // matched[0], any_active[1], zero fill [7:2]
   output logic [nbm_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                csr_we,
   input  logic [nbm_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [nbm_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import nbm_pkg::*;

   item_type     req_item;
   req_kind_type req_kind;
   ctl_type      ctl;
   desc_type     desc_chain [NODES];
   sweep_type    sweep_chain [NODES];
   logic         rsp_matched;
   logic         rsp_any_active;

   // Unpack the request beat
   assign req_kind = req_kind_type'(req_tuser);
   always_comb begin
      req_item.node_index      = req_tdata[5:0];
      req_item.node_is_epsilon = req_tdata[6];
      req_item.edge_first      = req_tdata[13:7];
      req_item.edge_second     = req_tdata[20:14];
      req_item.word_select     = req_tdata[22:21];
      req_item.set_word        = req_tdata[86:23];
      req_item.byte_in         = req_tdata[94:87];
   end

   nbm_ctrl #(
      .NODES (NODES)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_kind       (req_kind),
      .req_item       (req_item),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .sweep_last     (sweep_chain[NODES-1]),
      .ctl            (ctl),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_matched    (rsp_matched),
      .rsp_any_active (rsp_any_active)
   );

   // Ring of node cells: descriptors wrap around, lap flags run to the last cell
   for (genvar i = 0; i < NODES; i++) begin : g_cell
      sweep_type sweep_prev;
      if (i == 0) begin : g_head
         assign sweep_prev = '0;
      end else begin : g_body
         assign sweep_prev = sweep_chain[i-1];
      end

      nbm_cell #(
         .NODES (NODES),
         .Index (i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .desc_prev  (desc_chain[(i + NODES - 1) % NODES]),
         .sweep_prev (sweep_prev),
         .desc_out   (desc_chain[i]),
         .sweep_out  (sweep_chain[i])
      );
   end

   assign rsp_tdata = {{(RSP_DATA_W - 2){1'b0}}, rsp_any_active, rsp_matched};

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
   import nbm_pkg::*;

   localparam int NODE_COUNT = NODES_DEFAULT;

   typedef struct packed {
      req_kind_type      kind;
      logic [5:0]        node;
      logic              eps;
      logic signed [6:0] e1;
      logic signed [6:0] e2;
      logic [1:0]        sel;
      logic [63:0]       word;
      logic [7:0]        byt;
      logic              typed;
      logic              exp_m;
      logic              exp_a;
   } req_beat_t;

   typedef struct packed {
      logic matched;
      logic live;
   } match_flags_t;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic [REQ_USER_W-1:0]  req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // Matcher state mirrored by the testbench
   logic [63:0]       live_set;
   logic [63:0]       eps_mask;
   logic signed [6:0] out_a [NODE_COUNT];
   logic signed [6:0] out_b [NODE_COUNT];
   logic [63:0]       char_words [NODE_COUNT*4];
   logic [5:0]        start_reg;
   logic [6:0]        used_reg;

   // Scratch of one closure walk
   logic [63:0] seen_mask;
   logic [63:0] reach_mask;
   logic        accept_hit;
   int          walk_stack [$];

   match_flags_t pending_flags [$];
   int           miss_count = 0;
   int           results_seen = 0;
   int           beats_sent = 0;
   logic         last_live = 1'b1;
   logic         calm = 1'b0;

   nfa_byte_matcher dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Alternate busy stretches with calm ones where neither side idles
   always begin
      repeat (12000) @(posedge clock);
      calm <= 1'b1;
      repeat (3000) @(posedge clock);
      calm <= 1'b0;
   end

   function automatic logic idle_draw();
      return !calm && ($urandom_range(99) < 14);
   endfunction

   // Enter one edge target: flag accept, mark set nodes, stack epsilon nodes
   function automatic void enter_edge(logic signed [6:0] t, int n);
      int u;
      if (t == EDGE_ACCEPT) begin
         accept_hit = 1'b1;
         return;
      end
      if (t < 0 || int'(t) >= n) return;
      u = int'(t);
      if (seen_mask[u]) return;
      seen_mask[u] = 1'b1;
      if (eps_mask[u]) walk_stack.push_back(u);
      else reach_mask[u] = 1'b1;
   endfunction

   function automatic void drain_walk(int n);
      int u;
      while (walk_stack.size() > 0) begin
         u = walk_stack.pop_back();
         enter_edge(out_a[u], n);
         enter_edge(out_b[u], n);
      end
   endfunction

   function automatic void clear_walk();
      seen_mask = '0;
      reach_mask = '0;
      accept_hit = 1'b0;
      walk_stack.delete();
   endfunction

   function automatic void restart_walk(int n);
      clear_walk();
      enter_edge($signed({1'b0, start_reg}), n);
      drain_walk(n);
      live_set = reach_mask;
   endfunction

   // Apply one request to the mirrored state and return the flags it yields
   function automatic match_flags_t step_matcher(req_beat_t b);
      match_flags_t f;
      int n;
      int i;
      f.matched = 1'b0;
      f.live = 1'b0;
      n = (used_reg < 7'd64) ? int'(used_reg) : NODE_COUNT;
      case (b.kind)
         REQ_LOAD_DESC: begin
            eps_mask[b.node] = b.eps;
            out_a[b.node] = b.e1;
            out_b[b.node] = b.e2;
         end
         REQ_LOAD_SET: char_words[{b.node, b.sel}] = b.word;
         REQ_FEED: begin
            clear_walk();
            for (i = 0; i < n; i++) begin
               if (live_set[i] && !eps_mask[i] &&
                   char_words[i*4 + int'(b.byt[7:6])][b.byt[5:0]]) begin
                  enter_edge(out_a[i], n);
                  enter_edge(out_b[i], n);
                  drain_walk(n);
               end
            end
            live_set = reach_mask;
            f.matched = accept_hit;
         end
         default: restart_walk(n);
      endcase
      for (i = 0; i < n; i++)
         if (live_set[i]) f.live = 1'b1;
      return f;
   endfunction

   function automatic void reset_matcher();
      int i;
      eps_mask = '0;
      for (i = 0; i < NODE_COUNT; i++) begin
         out_a[i] = EDGE_NONE;
         out_b[i] = EDGE_NONE;
      end
      for (i = 0; i < NODE_COUNT*4; i++) char_words[i] = '0;
      start_reg = '0;
      used_reg = 7'd64;
      restart_walk(NODE_COUNT);
   endfunction

   function automatic req_beat_t rand_beat(req_kind_type k);
      req_beat_t b;
      b.kind = k;
      b.node = $urandom;
      b.eps = $urandom;
      b.e1 = $urandom;
      b.e2 = $urandom;
      b.sel = $urandom;
      b.word = {$urandom, $urandom};
      b.byt = $urandom;
      b.typed = 1'b0;
      b.exp_m = 1'b0;
      b.exp_a = 1'b0;
      return b;
   endfunction

   function automatic req_beat_t row(req_kind_type k, logic [5:0] node, logic eps,
                                     logic signed [6:0] e1, logic signed [6:0] e2,
                                     logic [1:0] sel, logic [63:0] word, logic [7:0] byt,
                                     logic typed, logic exp_m, logic exp_a);
      req_beat_t b;
      b = '{kind: k, node: node, eps: eps, e1: e1, e2: e2, sel: sel, word: word,
            byt: byt, typed: typed, exp_m: exp_m, exp_a: exp_a};
      return b;
   endfunction

   // Mostly node indexes inside the pattern, with accept, none and stray codes
   function automatic logic signed [6:0] pick_edge(int m);
      int r;
      r = $urandom_range(99);
      if (r < 12) return EDGE_ACCEPT;
      if (r < 22) return EDGE_NONE;
      if (r < 27) return $urandom;
      return $urandom_range(m - 1);
   endfunction

   function automatic logic [63:0] set_bits();
      case ($urandom_range(2))
         0: return {$urandom, $urandom} & {$urandom, $urandom};
         1: return {$urandom, $urandom};
         default: return {$urandom, $urandom} | {$urandom, $urandom};
      endcase
   endfunction

   task automatic report_miss(string what, logic [1:0] got, logic [1:0] want);
      $display("%0t ns result %0d: %s wrong, got %b want %b", $time, results_seen, what,
               got, want);
      miss_count++;
   endtask

   // Present one beat, hold it until taken, then queue its expected flags
   task automatic push_beat(req_beat_t b);
      match_flags_t f;
      while (idle_draw()) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= b.kind;
      req_tdata <= {1'b0, b.byt, b.word, b.sel, b.e2, b.e1, b.eps, b.node};
      do @(posedge clock); while (!req_tready);
      f = step_matcher(b);
      last_live = f.live;
      if (b.typed) begin
         f.matched = b.exp_m;
         f.live = b.exp_a;
      end
      pending_flags.push_back(f);
      beats_sent++;
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      if (idx == CSR_START_NODE) start_reg = val[5:0];
      else used_reg = val;
   endtask

   // Drop valid and let every outstanding result drain
   task automatic settle_block();
      req_tvalid <= 1'b0;
      while (pending_flags.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Result side: random backpressure
   always @(posedge clock) rsp_tready <= !reset && !idle_draw();

   // Compare each result beat with the oldest expectation
   always @(posedge clock) begin
      match_flags_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_flags.size() == 0) begin
            report_miss("beat with nothing pending", rsp_tdata[1:0], 2'bxx);
         end else begin
            want = pending_flags.pop_front();
            if (rsp_tdata[0] !== want.matched)
               report_miss("matched", rsp_tdata[1:0], {want.live, want.matched});
            if (rsp_tdata[1] !== want.live)
               report_miss("any_active", rsp_tdata[1:0], {want.live, want.matched});
         end
         results_seen++;
      end
   end

   initial begin
      req_beat_t  b;
      req_beat_t  directed_q [$];
      int         node;
      int         sel;
      int         phase;
      int         m;
      int         len;
      int         r;
      int         random_goal;
      logic [5:0] st;
      logic [6:0] used;
      logic       rb;

      reset_matcher();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Fill every set word once so no feed reads an unwritten one
      for (node = 0; node < NODE_COUNT; node++) begin
         for (sel = 0; sel < 4; sel++) begin
            b = rand_beat(REQ_LOAD_SET);
            b.node = node;
            b.sel = sel;
            b.word = set_bits();
            push_beat(b);
         end
      end

      // Two-node pattern: node 0 takes any byte, node 1 takes byte 0 or 255 to accept
      directed_q.push_back(row(REQ_LOAD_DESC, 0, 0, 1, EDGE_NONE, 0, 0, 0, 1, 0, 1));
      directed_q.push_back(row(REQ_LOAD_SET, 0, 0, 0, 0, 0, '1, 0, 1, 0, 1));
      directed_q.push_back(row(REQ_LOAD_SET, 0, 0, 0, 0, 1, '1, 0, 1, 0, 1));
      directed_q.push_back(row(REQ_LOAD_SET, 0, 0, 0, 0, 2, '1, 0, 1, 0, 1));
      directed_q.push_back(row(REQ_LOAD_SET, 0, 0, 0, 0, 3, '1, 0, 1, 0, 1));
      directed_q.push_back(row(REQ_LOAD_DESC, 1, 0, EDGE_ACCEPT, EDGE_NONE, 0, 0, 0,
                               1, 0, 1));
      directed_q.push_back(row(REQ_LOAD_SET, 1, 0, 0, 0, 0, 64'd1, 0, 1, 0, 1));
      directed_q.push_back(row(REQ_LOAD_SET, 1, 0, 0, 0, 1, '0, 0, 1, 0, 1));
      directed_q.push_back(row(REQ_LOAD_SET, 1, 0, 0, 0, 2, '0, 0, 1, 0, 1));
      directed_q.push_back(row(REQ_LOAD_SET, 1, 0, 0, 0, 3, 64'h8000_0000_0000_0000,
                               0, 1, 0, 1));
      directed_q.push_back(row(REQ_RESTART, 0, 0, 0, 0, 0, 0, 0, 1, 0, 1));
      directed_q.push_back(row(REQ_FEED, 0, 0, 0, 0, 0, 0, 8'd0, 1, 0, 1));
      directed_q.push_back(row(REQ_FEED, 0, 0, 0, 0, 0, 0, 8'd255, 1, 1, 0));
      directed_q.push_back(row(REQ_FEED, 0, 0, 0, 0, 0, 0, 8'd0, 1, 0, 0));
      directed_q.push_back(row(REQ_RESTART, 0, 0, 0, 0, 0, 0, 0, 1, 0, 1));
      directed_q.push_back(row(REQ_FEED, 0, 0, 0, 0, 0, 0, 8'd128, 1, 0, 1));
      directed_q.push_back(row(REQ_FEED, 0, 0, 0, 0, 0, 0, 8'd128, 1, 0, 0));
      // Epsilon loop between nodes 2 and 3 that also reaches accept and node 0
      directed_q.push_back(row(REQ_LOAD_DESC, 2, 1, 3, EDGE_ACCEPT, 0, 0, 0, 0, 0, 0));
      directed_q.push_back(row(REQ_LOAD_DESC, 3, 1, 2, 0, 0, 0, 0, 0, 0, 0));
      directed_q.push_back(row(REQ_LOAD_DESC, 0, 0, 2, 63, 0, 0, 0, 0, 0, 0));
      directed_q.push_back(row(REQ_RESTART, 0, 0, 0, 0, 0, 0, 0, 1, 0, 1));
      directed_q.push_back(row(REQ_FEED, 0, 0, 0, 0, 0, 0, 8'd64, 0, 0, 0));
      // Turn both live nodes into epsilon nodes, with stray edge codes on node 63
      directed_q.push_back(row(REQ_LOAD_DESC, 63, 1, -7'sd64, -7'sd3, 0, 0, 0, 0, 0, 0));
      directed_q.push_back(row(REQ_LOAD_DESC, 0, 1, EDGE_NONE, EDGE_NONE, 0, 0, 0,
                               0, 0, 0));
      directed_q.push_back(row(REQ_FEED, 0, 0, 0, 0, 0, 0, 8'd255, 1, 0, 0));
      foreach (directed_q[i]) push_beat(directed_q[i]);

      // Random phases: new settings, a fresh pattern, restart, then a text stream
      random_goal = beats_sent + 400;
      phase = 0;
      while (beats_sent < random_goal) begin
         settle_block();
         case (phase)
            0: begin m = 8;  used = 7'd64;  st = 6'd0;  end
            1: begin m = 6;  used = 7'd0;   st = 6'd0;  end
            2: begin m = 64; used = 7'd127; st = 6'd63; end
            3: begin m = 4;  used = 7'd1;   st = 6'd0;  end
            4: begin m = 5;  used = 7'd1;   st = 6'd63; end
            default: begin
               m = ($urandom_range(9) == 0) ? 64 : $urandom_range(2, 12);
               used = ($urandom_range(4) != 0) ? m : $urandom_range(127);
               st = ($urandom_range(4) != 0) ? $urandom_range(m - 1) : $urandom_range(63);
            end
         endcase
         rb = $urandom;
         if ($urandom_range(1)) begin
            write_reg(CSR_START_NODE, {rb, st});
            write_reg(CSR_ACTIVE_NODES, used);
         end else begin
            write_reg(CSR_ACTIVE_NODES, used);
            write_reg(CSR_START_NODE, {rb, st});
         end
         csr_we <= 1'b0;

         for (node = 0; node < m; node++) begin
            b = rand_beat(REQ_LOAD_DESC);
            b.node = node;
            b.eps = ($urandom_range(3) == 0);
            b.e1 = pick_edge(m);
            b.e2 = pick_edge(m);
            push_beat(b);
            for (sel = 0; sel < 4; sel++) begin
               if ($urandom_range(1)) begin
                  b = rand_beat(REQ_LOAD_SET);
                  b.node = node;
                  b.sel = sel;
                  b.word = set_bits();
                  push_beat(b);
               end
            end
         end
         push_beat(rand_beat(REQ_RESTART));

         len = $urandom_range(8, 40);
         repeat (len) begin
            r = $urandom_range(99);
            if (r < 7 || (!last_live && r < 30)) b = rand_beat(REQ_RESTART);
            else if (r < 33) b = rand_beat(REQ_LOAD_DESC);
            else if (r < 37) b = rand_beat(REQ_LOAD_SET);
            else b = rand_beat(REQ_FEED);
            if (r >= 30 && r < 33) b.kind = REQ_FEED;
            push_beat(b);
         end
         phase++;
      end

      // Drain and wait out a full closure walk
      req_tvalid <= 1'b0;
      while (pending_flags.size() != 0) @(posedge clock);
      repeat (2 * NODE_COUNT + 8) @(posedge clock);
      if (miss_count == 0 && pending_flags.size() == 0)
         $display("nfa_byte_matcher: match");
      else
         $display("nfa_byte_matcher: mismatch");
      $finish;
   end

   // Hard stop if the block hangs
   initial begin
      #250_000_000;
      $display("nfa_byte_matcher: mismatch");
      $finish;
   end

endmodule

/* nfa_byte_matcher.f */
hw/rtl/nbm_pkg.sv
hw/rtl/nbm_cell.sv
hw/rtl/nbm_ctrl.sv
hw/rtl/nfa_byte_matcher.sv
bench/tb_top.sv
